### sv/cldf_pkg.sv
`timescale 1ns / 1ps
// Package for the content-length deframer: phase and result codes, error codes,
// header flag bits, the length prefix table and the result struct. No dependencies.
package cldf_pkg;

   localparam int HeaderLimitWidth  = 16;
   localparam int MessageLimitWidth = 24;
   localparam int CountWidth        = 17;
   localparam int AccumWidth        = 28;
   localparam int PrefixLen         = 15;
   localparam int CsrDataWidth      = 24;

   // phase codes; code 3 behaves as failed
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_BODY   = 2'd1;
   localparam logic [1:0] PH_FAILED = 2'd2;

   // terminator match depth
   localparam logic [1:0] CM_NONE   = 2'd0;
   localparam logic [1:0] CM_CR     = 2'd1;
   localparam logic [1:0] CM_CRLF   = 2'd2;
   localparam logic [1:0] CM_CRLFCR = 2'd3;

   // header line flag bits
   localparam int LF_OTHER_BIT = 0;
   localparam int LF_VALUE_BIT = 1;
   localparam int LF_DIGIT_BIT = 2;

   localparam logic [1:0] RT_BODY  = 2'd0;
   localparam logic [1:0] RT_EMPTY = 2'd1;
   localparam logic [1:0] RT_ERROR = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_OVERSIZED = 3'd1;
   localparam logic [2:0] ERR_DUPLICATE = 3'd2;
   localparam logic [2:0] ERR_NO_DIGITS = 3'd3;
   localparam logic [2:0] ERR_BAD_DIGIT = 3'd4;
   localparam logic [2:0] ERR_MISSING   = 3'd5;

   localparam logic       CSR_HEADER_LIMIT  = 1'b0;
   localparam logic       CSR_MESSAGE_LIMIT = 1'b1;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic       valid;
      logic [1:0] result_type;
      logic [7:0] body_byte;
      logic       last_of_body;
      logic [2:0] error_code;
   } result_type;

   // "Content-Length:" one character per position
   function automatic logic [7:0] prefix_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h43; // C
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h4C; // L
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         4'd14:   ch = 8'h3A; // :
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### sv/cldf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the deframer: request bytes and results.
// Depends on nothing.
interface cldf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface cldf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_type;
   logic [7:0] body_byte;
   logic       last_of_body;
   logic [2:0] error_code;
   modport source (output valid, output result_type, output body_byte,
                   output last_of_body, output error_code, input ready);
   modport sink (input valid, input result_type, input body_byte,
                 input last_of_body, input error_code, output ready);
endinterface

### sv/cldf_parser.sv
`timescale 1ns / 1ps
// Deframer state and per-byte next-state logic: header scan, length parse, body count.
// Depends on cldf_pkg.
module cldf_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic [7:0]                            data_byte,
   input  logic [cldf_pkg::HeaderLimitWidth-1:0]  hdr_cap,
   input  logic [cldf_pkg::MessageLimitWidth-1:0] len_cap,
   output cldf_pkg::result_type                  result
);

   logic [1:0]                              phase_ff, phase_in;
   logic [1:0]                              crlf_ff, crlf_in;
   logic [cldf_pkg::CountWidth-1:0]         hcount_ff, hcount_in;
   logic [3:0]                              ppos_ff, ppos_in;
   logic [2:0]                              flags_ff, flags_in;
   logic [cldf_pkg::MessageLimitWidth-1:0]  lval_ff, lval_in;
   logic                                    lseen_ff, lseen_in;
   logic [2:0]                              herr_ff, herr_in;
   logic [cldf_pkg::MessageLimitWidth-1:0]  brem_ff, brem_in;

   always_comb begin
      logic                                    lb_do;
      logic                                    le_do;
      logic                                    term;
      logic [7:0]                              ch;
      logic [cldf_pkg::AccumWidth-1:0]         accum;
      logic [2:0]                              err;
      logic [cldf_pkg::CountWidth-1:0]         crlf_wide;

      phase_in  = phase_ff;
      crlf_in   = crlf_ff;
      hcount_in = hcount_ff;
      ppos_in   = ppos_ff;
      flags_in  = flags_ff;
      lval_in   = lval_ff;
      lseen_in  = lseen_ff;
      herr_in   = herr_ff;
      brem_in   = brem_ff;
      result    = '0;
      lb_do     = 1'b0;
      le_do     = 1'b0;
      term      = 1'b0;
      ch        = data_byte;
      accum     = '0;
      err       = cldf_pkg::ERR_NONE;
      crlf_wide = '0;

      if (step) begin
         unique case (phase_ff)
            cldf_pkg::PH_BODY: begin
               result.valid        = 1'b1;
               result.result_type  = cldf_pkg::RT_BODY;
               result.body_byte    = data_byte;
               result.last_of_body = (brem_ff <= 24'd1);
               if (result.last_of_body) begin
                  brem_in  = '0;
                  phase_in = cldf_pkg::PH_HEADER;
                  crlf_in  = cldf_pkg::CM_NONE;
                  hcount_in = '0;
                  ppos_in  = '0;
                  flags_in = '0;
                  lval_in  = '0;
                  lseen_in = 1'b0;
                  herr_in  = cldf_pkg::ERR_NONE;
               end else begin
                  brem_in = brem_ff - 24'd1;
               end
            end
            cldf_pkg::PH_HEADER: begin
               // a pending CR that is not part of the terminator is a header byte;
               // whatever follows it on that line cannot change the outcome
               unique case (crlf_ff)
                  cldf_pkg::CM_NONE: begin
                     if (data_byte == cldf_pkg::CHAR_CR) crlf_in = cldf_pkg::CM_CR;
                     else lb_do = 1'b1;
                  end
                  cldf_pkg::CM_CR: begin
                     if (data_byte == cldf_pkg::CHAR_LF) begin
                        le_do   = 1'b1;
                        crlf_in = cldf_pkg::CM_CRLF;
                     end else if (data_byte == cldf_pkg::CHAR_CR) begin
                        lb_do = 1'b1;
                        ch    = cldf_pkg::CHAR_CR;
                     end else begin
                        lb_do   = 1'b1;
                        ch      = cldf_pkg::CHAR_CR;
                        crlf_in = cldf_pkg::CM_NONE;
                     end
                  end
                  cldf_pkg::CM_CRLF: begin
                     if (data_byte == cldf_pkg::CHAR_CR) begin
                        crlf_in = cldf_pkg::CM_CRLFCR;
                     end else begin
                        lb_do   = 1'b1;
                        crlf_in = cldf_pkg::CM_NONE;
                     end
                  end
                  default: begin
                     if (data_byte == cldf_pkg::CHAR_LF) begin
                        term = 1'b1;
                     end else if (data_byte == cldf_pkg::CHAR_CR) begin
                        lb_do   = 1'b1;
                        ch      = cldf_pkg::CHAR_CR;
                        crlf_in = cldf_pkg::CM_CR;
                     end else begin
                        lb_do   = 1'b1;
                        ch      = cldf_pkg::CHAR_CR;
                        crlf_in = cldf_pkg::CM_NONE;
                     end
                  end
               endcase

               if (lb_do && herr_ff == cldf_pkg::ERR_NONE) begin
                  if (flags_ff[cldf_pkg::LF_VALUE_BIT]) begin
                     if (!flags_ff[cldf_pkg::LF_DIGIT_BIT] && ch == cldf_pkg::CHAR_SPACE) begin
                        herr_in = herr_ff;
                     end else if (ch < cldf_pkg::CHAR_ZERO || ch > cldf_pkg::CHAR_NINE) begin
                        herr_in = cldf_pkg::ERR_BAD_DIGIT;
                     end else begin
                        accum = ({4'd0, lval_ff} << 3) + ({4'd0, lval_ff} << 1)
                              + {24'd0, ch[3:0]};
                        if (accum > {4'd0, len_cap}) begin
                           herr_in = cldf_pkg::ERR_BAD_DIGIT;
                        end else begin
                           lval_in = accum[cldf_pkg::MessageLimitWidth-1:0];
                           flags_in[cldf_pkg::LF_DIGIT_BIT] = 1'b1;
                        end
                     end
                  end else if (!flags_ff[cldf_pkg::LF_OTHER_BIT]) begin
                     if (ppos_ff < 4'(cldf_pkg::PrefixLen)
                         && ch == cldf_pkg::prefix_char(ppos_ff)) begin
                        ppos_in = ppos_ff + 4'd1;
                        if (ppos_in == 4'(cldf_pkg::PrefixLen)) begin
                           if (lseen_ff) herr_in = cldf_pkg::ERR_DUPLICATE;
                           else flags_in[cldf_pkg::LF_VALUE_BIT] = 1'b1;
                        end
                     end else begin
                        flags_in[cldf_pkg::LF_OTHER_BIT] = 1'b1;
                     end
                  end
               end

               if (le_do) begin
                  if (herr_ff == cldf_pkg::ERR_NONE && flags_ff[cldf_pkg::LF_VALUE_BIT]) begin
                     if (flags_ff[cldf_pkg::LF_DIGIT_BIT]) lseen_in = 1'b1;
                     else herr_in = cldf_pkg::ERR_NO_DIGITS;
                  end
                  flags_in = '0;
                  ppos_in  = '0;
               end

               if (term) begin
                  err = herr_ff;
                  if (err == cldf_pkg::ERR_NONE && !lseen_ff) err = cldf_pkg::ERR_MISSING;
                  if (err != cldf_pkg::ERR_NONE) begin
                     result.valid       = 1'b1;
                     result.result_type = cldf_pkg::RT_ERROR;
                     result.error_code  = err;
                     phase_in           = cldf_pkg::PH_FAILED;
                  end else begin
                     if (lval_ff == '0) begin
                        result.valid        = 1'b1;
                        result.result_type  = cldf_pkg::RT_EMPTY;
                        result.last_of_body = 1'b1;
                     end else begin
                        brem_in  = lval_ff;
                        phase_in = cldf_pkg::PH_BODY;
                     end
                     crlf_in   = cldf_pkg::CM_NONE;
                     hcount_in = '0;
                     ppos_in   = '0;
                     flags_in  = '0;
                     lval_in   = '0;
                     lseen_in  = 1'b0;
                     herr_in   = cldf_pkg::ERR_NONE;
                  end
               end else begin
                  hcount_in = hcount_ff + 17'd1;
                  crlf_wide = {15'd0, crlf_in};
                  if (hcount_in >= crlf_wide
                      && (hcount_in - crlf_wide) > {1'b0, hdr_cap}) begin
                     result.valid       = 1'b1;
                     result.result_type = cldf_pkg::RT_ERROR;
                     result.error_code  = cldf_pkg::ERR_OVERSIZED;
                     phase_in           = cldf_pkg::PH_FAILED;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= cldf_pkg::PH_HEADER;
         crlf_ff   <= cldf_pkg::CM_NONE;
         hcount_ff <= '0;
         ppos_ff   <= '0;
         flags_ff  <= '0;
         lval_ff   <= '0;
         lseen_ff  <= 1'b0;
         herr_ff   <= cldf_pkg::ERR_NONE;
         brem_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         crlf_ff   <= crlf_in;
         hcount_ff <= hcount_in;
         ppos_ff   <= ppos_in;
         flags_ff  <= flags_in;
         lval_ff   <= lval_in;
         lseen_ff  <= lseen_in;
         herr_ff   <= herr_in;
         brem_ff   <= brem_in;
      end
   end

endmodule

### sv/content_length_deframer_core.sv
`timescale 1ns / 1ps
// Content-Length deframer top level: input register, parser, result register, CSRs.
// Depends on cldf_pkg, cldf_if.sv and cldf_parser.
//
// Usage:
//   req_if carries one raw stream byte per item. The header is scanned for the
//   line starting with "Content-Length:", ends at the first CR LF CR LF, and the
//   body that follows is passed out on rsp_if one byte per item, the final byte
//   marked with last_of_body. A zero length gives one empty-message item.
//   Header faults give one error item; the block then drops every byte until
//   reset.
//   csr_wr_en writes the header size cap (index 0) or the body length cap
//   (index 1) from csr_wdata; write only while the block is idle.
// Timing:
//   A byte is registered in the input register, and the parser's result for it
//   is registered in the result register once that slot is free.
//   One item per cycle is sustained while rsp_if.ready stays high; the parser
//   step is a single pass of compare, multiply-by-ten and count logic.
// Reset:
//   Synchronous, active high: header phase, empty pipeline, limits at defaults.
// Stall:
//   While rsp_if.ready is low and a result waits, the held input byte stays in
//   the input register and req_if.ready drops once that register is full.
module content_length_deframer_core (
   input  logic                                clock,
   input  logic                                reset,
   cldf_req_if.sink                            req_if,
   cldf_rsp_if.source                          rsp_if,
   input  logic                                csr_wr_en,
   input  logic                                csr_index,
   input  logic [cldf_pkg::CsrDataWidth-1:0]    csr_wdata
);

   logic                                    in_valid_ff, in_valid_in;
   logic [7:0]                              in_byte_ff;
   logic                                    out_valid_ff, out_valid_in;
   cldf_pkg::result_type                    out_ff;
   logic [cldf_pkg::HeaderLimitWidth-1:0]   hdr_cap_ff;
   logic [cldf_pkg::MessageLimitWidth-1:0]  len_cap_ff;
   logic                                    out_free;
   logic                                    step;
   cldf_pkg::result_type                    step_result;

   // the result slot is free when empty or being drained this cycle
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || step;

   // hold the byte until the parser takes it
   assign in_valid_in  = req_if.valid ? 1'b1 : (in_valid_ff && !step);
   assign out_valid_in = out_free ? (step && step_result.valid) : out_valid_ff;

   cldf_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (in_byte_ff),
      .hdr_cap       (hdr_cap_ff),
      .len_cap       (len_cap_ff),
      .result        (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: advance without reset
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) in_byte_ff <= req_if.data_byte;
      if (step && step_result.valid) out_ff <= step_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cap_ff <= 16'd16384;
         len_cap_ff <= 24'd8388608;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cldf_pkg::CSR_HEADER_LIMIT:
               hdr_cap_ff <= csr_wdata[cldf_pkg::HeaderLimitWidth-1:0];
            cldf_pkg::CSR_MESSAGE_LIMIT:
               len_cap_ff <= csr_wdata[cldf_pkg::MessageLimitWidth-1:0];
            default: begin
               hdr_cap_ff <= hdr_cap_ff;
            end
         endcase
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.result_type  = out_ff.result_type;
   assign rsp_if.body_byte    = out_ff.body_byte;
   assign rsp_if.last_of_body = out_ff.last_of_body;
   assign rsp_if.error_code   = out_ff.error_code;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for content_length_deframer_core: feeds framed byte streams,
// mirrors the header parser in a small class and checks body, empty and error items.
// Depends on cldf_pkg, cldf_if.sv and the core RTL.
module tb;
   import cldf_pkg::*;

   localparam int ClockHalf    = 2;
   localparam int CycleLimit   = 400000;
   localparam int RandomBytes  = 1800;
   localparam int SettleCycles = 6;
   localparam int HoldCycles   = 250;
   localparam logic [8*PrefixLen-1:0] LengthKey = "Content-Length:";

   typedef struct packed {
      logic [1:0] result_type;
      logic [7:0] body_byte;
      logic       last_of_body;
      logic [2:0] error_code;
   } frame_out_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_type;

   // Shadow of the deframer: header scan, length accumulation, body count and
   // the queue of items the block still owes.
   class deframer_state;
      logic [15:0] hdr_cap;
      logic [23:0] len_cap;
      logic [1:0]  phase;
      logic [1:0]  crlf_depth;
      logic [16:0] header_bytes;
      logic [3:0]  key_pos;
      bit          other_line;
      bit          in_value;
      bit          digit_seen;
      logic [23:0] length_value;
      bit          length_seen;
      logic [2:0]  held_error;
      logic [23:0] body_left;
      frame_out_type owed[$];
      int          faults;

      function new();
         faults = 0;
         hdr_cap = 16'd16384;
         len_cap = 24'd8388608;
         phase = PH_HEADER;
         body_left = '0;
         clear_header();
      endfunction

      function void clear_header();
         crlf_depth = CM_NONE;
         header_bytes = '0;
         key_pos = '0;
         other_line = 1'b0;
         in_value = 1'b0;
         digit_seen = 1'b0;
         length_value = '0;
         length_seen = 1'b0;
         held_error = ERR_NONE;
      endfunction

      function void owe(logic [1:0] kind, logic [7:0] data, logic last, logic [2:0] code);
         frame_out_type item;
         item.result_type = kind;
         item.body_byte = data;
         item.last_of_body = last;
         item.error_code = code;
         owed.insert(owed.size(), item);
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // one byte of a header line (terminator bytes excluded)
      function void scan_char(logic [7:0] c);
         logic [31:0] grown;
         if (held_error != ERR_NONE) return;
         if (in_value) begin
            if (!digit_seen && c == CHAR_SPACE) return;
            if (c < CHAR_ZERO || c > CHAR_NINE) begin
               held_error = ERR_BAD_DIGIT;
               return;
            end
            grown = {8'd0, length_value} * 32'd10 + {24'd0, c - CHAR_ZERO};
            if (grown > {8'd0, len_cap}) begin
               held_error = ERR_BAD_DIGIT;
               return;
            end
            length_value = grown[23:0];
            digit_seen = 1'b1;
            return;
         end
         if (other_line) return;
         if (key_pos < PrefixLen &&
             c == LengthKey[8*(PrefixLen-1-int'(key_pos)) +: 8]) begin
            key_pos++;
            if (key_pos == PrefixLen) begin
               if (length_seen) held_error = ERR_DUPLICATE;
               else in_value = 1'b1;
            end
         end else begin
            other_line = 1'b1;
         end
      endfunction

      function void end_line();
         if (held_error == ERR_NONE && in_value) begin
            if (digit_seen) length_seen = 1'b1;
            else held_error = ERR_NO_DIGITS;
         end
         other_line = 1'b0;
         in_value = 1'b0;
         digit_seen = 1'b0;
         key_pos = '0;
      endfunction

      function void take_byte(logic [7:0] b);
         logic       last;
         logic [2:0] code;
         if (phase == PH_BODY) begin
            last = (body_left <= 24'd1);
            owe(RT_BODY, b, last, ERR_NONE);
            if (last) begin
               body_left = '0;
               phase = PH_HEADER;
               clear_header();
            end else begin
               body_left--;
            end
            return;
         end
         if (phase != PH_HEADER) return;
         case (crlf_depth)
            CM_NONE: begin
               if (b == CHAR_CR) crlf_depth = CM_CR;
               else scan_char(b);
            end
            CM_CR: begin
               if (b == CHAR_LF) begin
                  end_line();
                  crlf_depth = CM_CRLF;
               end else if (b == CHAR_CR) begin
                  scan_char(CHAR_CR);
               end else begin
                  scan_char(CHAR_CR);
                  scan_char(b);
                  crlf_depth = CM_NONE;
               end
            end
            CM_CRLF: begin
               if (b == CHAR_CR) crlf_depth = CM_CRLFCR;
               else begin
                  scan_char(b);
                  crlf_depth = CM_NONE;
               end
            end
            default: begin
               if (b == CHAR_LF) begin
                  code = held_error;
                  if (code == ERR_NONE && !length_seen) code = ERR_MISSING;
                  if (code != ERR_NONE) begin
                     owe(RT_ERROR, 8'd0, 1'b0, code);
                     phase = PH_FAILED;
                  end else if (length_value == 0) begin
                     owe(RT_EMPTY, 8'd0, 1'b1, ERR_NONE);
                     clear_header();
                  end else begin
                     body_left = length_value;
                     phase = PH_BODY;
                     clear_header();
                  end
                  return;
               end
               scan_char(CHAR_CR);
               if (b == CHAR_CR) crlf_depth = CM_CR;
               else begin
                  scan_char(b);
                  crlf_depth = CM_NONE;
               end
            end
         endcase
         header_bytes = header_bytes + 17'd1;
         if (header_bytes >= 17'(crlf_depth) &&
             header_bytes - 17'(crlf_depth) > 17'(hdr_cap)) begin
            owe(RT_ERROR, 8'd0, 1'b0, ERR_OVERSIZED);
            phase = PH_FAILED;
         end
      endfunction

      function void flag_field(string field, int want, int got);
         faults++;
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      endfunction

      function void check_output(frame_out_type got);
         frame_out_type want;
         if (owed.size() == 0) begin
            faults++;
            $display("%0t: item with nothing pending, expected none, got type %0d byte %0h",
                     $time, got.result_type, got.body_byte);
            return;
         end
         want = owed.pop_front();
         if (want.result_type !== got.result_type)
            flag_field("result_type", want.result_type, got.result_type);
         if (want.body_byte !== got.body_byte)
            flag_field("body_byte", want.body_byte, got.body_byte);
         if (want.last_of_body !== got.last_of_body)
            flag_field("last_of_body", want.last_of_body, got.last_of_body);
         if (want.error_code !== got.error_code)
            flag_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic                    csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   cldf_req_if req_ch();
   cldf_rsp_if rsp_ch();

   content_length_deframer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   deframer_state  mirror = new();
   logic [7:0]     stream[$];
   int             bytes_sent = 0;
   int             outputs_seen = 0;
   int             cycles = 0;
   int             burst_left = 0;
   int             next_hold_at = 120;
   int             hold_left = 0;
   int             rx_left = 0;
   rx_pattern_type rx_pattern = RX_OPEN;

   initial begin
      clock = 1'b0;
      forever #(ClockHalf) clock = ~clock;
   end

   // Watchdog: end the run if it drags far past any correct schedule.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: check each accepted item against the oldest owed one, then
   // pick ready for the next edge. Hold off for a long stretch at a few
   // milestones so the core backs up and stalls its input.
   always @(posedge clock) begin : rx_side
      frame_out_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.result_type = rsp_ch.result_type;
         got.body_byte = rsp_ch.body_byte;
         got.last_of_body = rsp_ch.last_of_body;
         got.error_code = rsp_ch.error_code;
         mirror.check_output(got);
         outputs_seen++;
      end
      if (outputs_seen >= next_hold_at) begin
         hold_left = HoldCycles;
         next_hold_at += 580;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_pattern = rx_pattern_type'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
         end
         rx_left--;
         case (rx_pattern)
            RX_OPEN:   rsp_ch.ready <= 1'b1;
            RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ch.ready <= ~rsp_ch.ready;
         endcase
      end
   end

   // Offer one byte; bursts of random length with random gaps between them.
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      mirror.take_byte(b);
      bytes_sent++;
   endtask

   task automatic send_stream();
      foreach (stream[i]) push_byte(stream[i]);
      stream.delete();
   endtask

   // Stop offering, wait for every owed item, then let the pipeline settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic program_limits(input logic [15:0] hl, input logic [23:0] ml);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HEADER_LIMIT;
      csr_wdata <= {8'd0, hl};
      @(posedge clock);
      csr_index <= CSR_MESSAGE_LIMIT;
      csr_wdata <= ml;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror.hdr_cap = hl;
      mirror.len_cap = ml;
   endtask

   function automatic void add_byte(input logic [7:0] b);
      stream.insert(stream.size(), b);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void add_crlf();
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
   endfunction

   function automatic void add_random(input int n);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_length_line(input int value, input int spaces, input int zeros);
      add_text("Content-Length:");
      repeat (spaces) add_byte(CHAR_SPACE);
      repeat (zeros) add_byte(CHAR_ZERO);
      add_text($sformatf("%0d", value));
   endfunction

   // Any header line other than the length line; never holds CR LF inside.
   function automatic int add_other_line(input int room);
      string      text;
      logic [7:0] ch;
      logic [7:0] prev;
      int         len;
      case ($urandom_range(0, 3))
         0:       text = "Content-Type: text";
         1:       text = "content-length: 12";
         2:       text = "Content-Lengthy:7";
         default: text = "";
      endcase
      if (text.len() != 0 && text.len() <= room) begin
         add_text(text);
         return text.len();
      end
      len = $urandom_range(1, (room < 24) ? room : 24);
      prev = 8'h00;
      for (int i = 0; i < len; i++) begin
         ch = 8'($urandom_range(0, 255));
         if (prev == CHAR_CR && ch == CHAR_LF) ch = CHAR_SPACE;
         add_byte(ch);
         prev = ch;
      end
      return len;
   endfunction

   // One well-formed message whose header fits the header limit and whose
   // length stays within the message limit; random extra lines and body.
   function automatic void queue_message(input int hl, input int ml, input int cap);
      int    value;
      int    spaces;
      int    zeros;
      int    used;
      int    n_lines;
      int    key_at;
      int    room;
      string digits;
      value = $urandom_range(0, (ml < cap) ? ml : cap);
      spaces = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
      digits = $sformatf("%0d", value);
      used = PrefixLen + spaces + zeros + digits.len();
      if (used > hl) begin
         spaces = 0;
         zeros = 0;
         value = $urandom_range(0, 9);
         used = PrefixLen + 1;
      end
      n_lines = $urandom_range(0, 3);
      key_at = $urandom_range(0, n_lines);
      if (used + 2 <= hl && $urandom_range(0, 5) == 0) begin
         add_crlf();
         used += 2;
      end
      for (int i = 0; i <= n_lines; i++) begin
         if (i == key_at) begin
            add_length_line(value, spaces, zeros);
            add_crlf();
         end else begin
            room = hl - used - 2;
            if (room >= 1) begin
               used += add_other_line(room) + 2;
               add_crlf();
            end
         end
      end
      add_crlf();
      add_random(value);
   endfunction

   initial begin : stimulus
      int hl;
      int ml;
      int kind;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data_byte <= 8'd0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_HEADER_LIMIT;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset limits: empty body, then padded value with a header
      // line full of lone CRs and a body of extreme and CR/LF bytes.
      add_length_line(0, 0, 0);
      add_crlf();
      add_crlf();
      add_length_line(7, 3, 2);
      add_crlf();
      add_text("X-Tag:");
      add_byte(CHAR_CR);
      add_byte(8'h01);
      add_byte(CHAR_CR);
      add_byte(CHAR_CR);
      add_crlf();
      add_crlf();
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
      add_byte(8'h80);
      // leading blank line and a line that shares only part of the prefix
      add_crlf();
      add_text("Content-Type: a");
      add_crlf();
      add_length_line(1, 1, 0);
      add_crlf();
      add_crlf();
      add_byte(8'h55);
      send_stream();

      // Smallest limits: a header of exactly the limit.
      drain();
      program_limits(16'd16, 24'd16);
      add_length_line(9, 0, 0);
      add_crlf();
      add_crlf();
      add_random(9);
      send_stream();

      // Length equal to the smallest message limit.
      drain();
      program_limits(16'd65535, 24'd16);
      add_length_line(16, 0, 0);
      add_crlf();
      add_crlf();
      add_random(16);
      send_stream();

      // Largest limits; prefix that runs one letter past the key.
      drain();
      program_limits(16'd65535, 24'd16777215);
      add_text("Content-Lengthx: 1");
      add_crlf();
      add_length_line(2, 1, 0);
      add_crlf();
      add_crlf();
      add_random(2);
      send_stream();

      // Random phases: pause, retune the limits, then a run of messages.
      while (bytes_sent < RandomBytes) begin
         drain();
         case ($urandom_range(0, 3))
            0: program_limits(16'($urandom_range(16, 40)), 24'($urandom_range(16, 40)));
            1: program_limits(16'd65535, 24'd16777215);
            2: program_limits(16'($urandom_range(16, 65535)),
                              24'($urandom_range(16, 16777215)));
            default: ;
         endcase
         repeat ($urandom_range(3, 8)) begin
            if (bytes_sent < RandomBytes) begin
               queue_message(mirror.hdr_cap, mirror.len_cap, 48);
               send_stream();
            end
         end
      end

      // A fault is final until reset, so close the run with one broken
      // header of a random kind, then bytes that the failed block drops.
      drain();
      kind = $urandom_range(0, 7);
      hl = (kind == 0 || kind == 6) ? $urandom_range(16, 200) : 65535;
      ml = $urandom_range(16, 1000);
      program_limits(16'(hl), 24'(ml));
      case (kind)
         0: begin
            // oversized header
            add_length_line(3, 0, 0);
            add_crlf();
            repeat (hl) add_byte(8'h61);
         end
         1: begin
            // duplicate length line
            add_length_line(1, 0, 0);
            add_crlf();
            add_length_line(1, 0, 0);
            add_crlf();
            add_crlf();
         end
         2: begin
            // length line with spaces only
            add_text("Content-Length:  ");
            add_crlf();
            add_crlf();
         end
         3: begin
            // lone CR inside the value
            add_length_line(1, 1, 0);
            add_byte(CHAR_CR);
            add_text("2");
            add_crlf();
            add_crlf();
         end
         4: begin
            // value one past the message limit
            add_length_line(ml + 1, 0, 0);
            add_crlf();
            add_crlf();
         end
         5: begin
            // no length line at all
            add_text("Host: x");
            add_crlf();
            add_crlf();
         end
         6: begin
            // held line fault overtaken by an oversized header
            add_text("Content-Length:");
            add_crlf();
            repeat (hl) add_byte(8'h61);
         end
         default: begin
            // trailing space after the digits
            add_length_line(12, 1, 0);
            add_text(" ");
            add_crlf();
            add_crlf();
         end
      endcase
      add_random(24);
      send_stream();
      drain();

      if (mirror.faults == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
